// ===== rtl/sbft_pkg.sv =====
`timescale 1ns / 1ps

package sbft_pkg;

   localparam int DEF_ENTRIES = 256;
   localparam int CMD_W       = 3;
   localparam int KEY_W       = 8;
   localparam int CNT_W       = 32;
   localparam int RANK_W      = 8;
   localparam int ACT_W       = 9;

   localparam logic [CMD_W-1:0] CMD_INC    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEC    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QRANK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QKEY   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [KEY_W-1:0]  key;
      logic [CNT_W-1:0]  amount;
      logic [RANK_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [KEY_W-1:0]  key_out;
      logic [CNT_W-1:0]  count_out;
      logic [RANK_W-1:0] rank_out;
      logic [ACT_W-1:0]  active_out;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } ent_type;

   typedef enum logic [0:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_RANK,
      ST_ENTRY,
      ST_REMOVE,
      ST_UP,
      ST_DOWN,
      ST_RESPOND
   } state_type;

endpackage

// ===== rtl/sbft_ram.sv =====
`timescale 1ns / 1ps

module sbft_ram import sbft_pkg::*; #(
   parameter int DEPTH = DEF_ENTRIES,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = KEY_W
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sbft_alu.sv =====
`timescale 1ns / 1ps

module sbft_alu import sbft_pkg::*; (
   input  alu_op_type       op,
   input  logic [CNT_W-1:0] a,
   input  logic [CNT_W-1:0] b,
   output logic [CNT_W-1:0] value,
   output logic             flag
);

   logic             sub;
   logic [CNT_W-1:0] b_eff;
   logic [CNT_W:0]   sum;

   always_comb begin
      sub   = (op == ALU_SUB);
      b_eff = sub ? ~b : b;
      sum   = {1'b0, a} + {1'b0, b_eff} + {{CNT_W{1'b0}}, sub};
      if (sub) begin
         // borrow: a < b
         flag  = ~sum[CNT_W];
         value = sum[CNT_W-1:0];
      end else begin
         // saturate on carry out
         flag  = sum[CNT_W];
         value = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
      end
   end

endmodule

// ===== rtl/sorted_byte_frequency_table_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_data  (command, key, amount, rank)
// rsp      out        rsp_valid/rsp_stall  rsp_data  (ok, key_out, count_out, rank_out,
//                                                      active_out)
// After an accept: rank queries read the entry by rank; key queries and refused updates
// read the key map, then the entry; unknown codes and keys beyond the table skip both.
// Increase, decrease and remove then swap neighbors, one table memory read per swap.
// After reset a clearing pass over all ENTRIES positions loads the tables; req_stall stays high.
// req_stall is high from acceptance until the result is loaded into the output register.
// A result held under rsp_stall does not block the next item from being accepted.

module sorted_byte_frequency_table_unit import sbft_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [ACT_W-1:0] ENT_CNT = ACT_W'(ENTRIES);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] amount_ff, amount_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] val_ff, val_in;
   logic [KEY_W-1:0] sk_ff, sk_in;
   logic [ACT_W-1:0] active_ff, active_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ent_we;
   logic [IDX_W-1:0] ent_waddr, ent_raddr;
   ent_type          ent_wdata, ent_rd;
   logic [$bits(ent_type)-1:0] ent_rdata;
   logic             map_we;
   logic [IDX_W-1:0] map_waddr, map_raddr;
   logic [KEY_W-1:0] map_wdata, map_rdata;

   alu_op_type       alu_op;
   logic [CNT_W-1:0] alu_a, alu_b, alu_value;
   logic             alu_flag;

   logic             req_accept;
   logic             direct_cmd;
   logic             key_in_range;
   logic [ACT_W-1:0] pos_ext, pos_up1, pos_up2, pos_dn2, rank_ext, last_ext;
   logic [IDX_W-1:0] last_idx;
   logic             pos_active;
   logic             up_move;
   logic             down_move;
   logic             out_free;

   sbft_ram #(
      .DEPTH (ENTRIES),
      .AW    (IDX_W),
      .DW    ($bits(ent_type))
   ) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   sbft_ram #(
      .DEPTH (ENTRIES),
      .AW    (IDX_W),
      .DW    (KEY_W)
   ) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   sbft_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .value (alu_value),
      .flag  (alu_flag)
   );

   assign ent_rd     = ent_type'(ent_rdata);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      direct_cmd   = (req_data.command == CMD_INC) || (req_data.command == CMD_DEC) ||
                     (req_data.command == CMD_REMOVE) || (req_data.command == CMD_QKEY);
      key_in_range = ACT_W'(req_data.key) < ENT_CNT;
      pos_ext      = ACT_W'(pos_ff);
      pos_up1      = pos_ext + ACT_W'(1);
      pos_up2      = pos_ext + ACT_W'(2);
      pos_dn2      = pos_ext - ACT_W'(2);
      rank_ext     = ACT_W'(rank_ff);
      last_ext     = active_ff - ACT_W'(1);
      last_idx     = last_ext[IDX_W-1:0];
      pos_active   = pos_ext < active_ff;
      up_move      = (pos_up1 < active_ff) && alu_flag;
      down_move    = (pos_ff != '0) && alu_flag;
      out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = val_ff;
      alu_b  = ent_rd.count;
      unique case (state_ff)
         ST_ENTRY: begin
            alu_op = (cmd_ff == CMD_INC) ? ALU_ADD : ALU_SUB;
            alu_a  = ent_rd.count;
            alu_b  = amount_ff;
         end
         ST_UP: begin
            alu_a = ent_rd.count;
            alu_b = val_ff;
         end
         default: begin
            alu_op = ALU_SUB;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_QRANK) state_in = ST_RANK;
               else if (direct_cmd && key_in_range) state_in = ST_MAP;
               else state_in = ST_RESPOND;
            end
         end
         ST_MAP: begin
            state_in = ST_ENTRY;
         end
         ST_RANK: begin
            state_in = ST_RESPOND;
         end
         ST_ENTRY: begin
            if (cmd_ff == CMD_QKEY || !pos_active) state_in = ST_RESPOND;
            else if (cmd_ff == CMD_INC) state_in = ST_UP;
            else if (cmd_ff == CMD_DEC) state_in = alu_flag ? ST_RESPOND : ST_DOWN;
            else state_in = ST_REMOVE;
         end
         ST_REMOVE: begin
            state_in = (pos_ff != last_idx) ? ST_UP : ST_RESPOND;
         end
         ST_UP: begin
            if (!up_move) state_in = ST_RESPOND;
         end
         ST_DOWN: begin
            if (!down_move) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      amount_in    = amount_ff;
      rank_in      = rank_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      sk_in        = sk_ff;
      active_in    = active_ff;
      res_in       = res_ff;
      ent_we       = 1'b0;
      ent_waddr    = pos_ff;
      ent_wdata    = ent_rd;
      ent_raddr    = pos_ff;
      map_we       = 1'b0;
      map_waddr    = ent_rd.key[IDX_W-1:0];
      map_wdata    = KEY_W'(pos_ff);
      map_raddr    = req_data.key[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ent_we          = 1'b1;
            ent_waddr       = clr_ff;
            ent_wdata.key   = KEY_W'(clr_ff);
            ent_wdata.count = '0;
            map_we          = 1'b1;
            map_waddr       = clr_ff;
            map_wdata       = KEY_W'(clr_ff);
            clr_in          = clr_ff + IDX_W'(1);
            active_in       = ENT_CNT;
         end
         ST_IDLE: begin
            ent_raddr = req_data.rank[IDX_W-1:0];
            if (req_accept) begin
               cmd_in    = req_data.command;
               key_in    = req_data.key;
               amount_in = req_data.amount;
               rank_in   = req_data.rank;
               res_in    = '0;
               if (direct_cmd) res_in.key_out = req_data.key;
            end
         end
         ST_MAP: begin
            pos_in    = map_rdata[IDX_W-1:0];
            ent_raddr = map_rdata[IDX_W-1:0];
         end
         ST_RANK: begin
            res_in          = '0;
            res_in.rank_out = rank_ff;
            if (rank_ext < ENT_CNT) begin
               res_in.key_out   = ent_rd.key;
               res_in.count_out = ent_rd.count;
               res_in.ok        = rank_ext < active_ff;
            end
         end
         ST_ENTRY: begin
            res_in.ok        = 1'b0;
            res_in.key_out   = key_ff;
            res_in.count_out = ent_rd.count;
            res_in.rank_out  = RANK_W'(pos_ff);
            sk_in            = key_ff;
            if (cmd_ff == CMD_QKEY || !pos_active) begin
               res_in.ok = (cmd_ff == CMD_QKEY) && pos_active;
            end else if (cmd_ff == CMD_INC) begin
               val_in    = alu_value;
               ent_raddr = pos_up1[IDX_W-1:0];
            end else if (cmd_ff == CMD_DEC) begin
               val_in    = alu_value;
               ent_raddr = pos_ff - IDX_W'(1);
            end else begin
               val_in    = ent_rd.count;
               ent_raddr = last_idx;
            end
         end
         ST_REMOVE: begin
            ent_we           = 1'b1;
            ent_waddr        = last_idx;
            ent_wdata.key    = key_ff;
            ent_wdata.count  = val_ff;
            map_we           = 1'b1;
            map_waddr        = key_ff[IDX_W-1:0];
            map_wdata        = KEY_W'(last_idx);
            active_in        = last_ext;
            res_in.ok        = 1'b1;
            res_in.key_out   = key_ff;
            res_in.count_out = val_ff;
            res_in.rank_out  = RANK_W'(last_idx);
            sk_in            = ent_rd.key;
            val_in           = ent_rd.count;
            ent_raddr        = pos_up1[IDX_W-1:0];
         end
         ST_UP: begin
            ent_we    = 1'b1;
            ent_waddr = pos_ff;
            map_we    = 1'b1;
            if (up_move) begin
               pos_in    = pos_up1[IDX_W-1:0];
               ent_raddr = pos_up2[IDX_W-1:0];
            end else begin
               ent_wdata.key   = sk_ff;
               ent_wdata.count = val_ff;
               map_waddr       = sk_ff[IDX_W-1:0];
               if (cmd_ff != CMD_REMOVE) begin
                  res_in.ok        = 1'b1;
                  res_in.key_out   = key_ff;
                  res_in.count_out = val_ff;
                  res_in.rank_out  = RANK_W'(pos_ff);
               end
            end
         end
         ST_DOWN: begin
            ent_we    = 1'b1;
            ent_waddr = pos_ff;
            map_we    = 1'b1;
            if (down_move) begin
               pos_in    = pos_ff - IDX_W'(1);
               ent_raddr = pos_dn2[IDX_W-1:0];
            end else begin
               ent_wdata.key    = sk_ff;
               ent_wdata.count  = val_ff;
               map_waddr        = sk_ff[IDX_W-1:0];
               res_in.ok        = 1'b1;
               res_in.key_out   = key_ff;
               res_in.count_out = val_ff;
               res_in.rank_out  = RANK_W'(pos_ff);
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = res_ff;
               rsp_in.active_out = active_ff;
            end
         end
         default: begin
            ent_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         active_ff    <= ENT_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      amount_ff <= amount_in;
      rank_ff   <= rank_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      sk_ff     <= sk_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== rtl/sbft_checker.sv =====
`timescale 1ns / 1ps

module sbft_checker import sbft_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is at work");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("item traffic during table clearing");

   a_rank_in_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ok |->
         ({1'b0, rsp_data.rank_out} <= rsp_data.active_out) &&
         (rsp_data.active_out <= ACT_W'(ENTRIES)))
      else $error("successful item reports a rank outside the active region");

endmodule

bind sorted_byte_frequency_table_unit sbft_checker #(.ENTRIES(ENTRIES)) u_sbft_checker (.*);

// ===== bench/rank_table_checker.sv =====
`timescale 1ns / 1ps

module rank_table_checker import sbft_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      outstanding,
   output int      fail_count,
   output int      checked
);

   logic [KEY_W-1:0]  key_at   [DEF_ENTRIES];
   logic [CNT_W-1:0]  count_at [DEF_ENTRIES];
   logic [RANK_W-1:0] rank_of  [DEF_ENTRIES];
   int unsigned       live;
   rsp_type           pending_results [$];

   initial begin
      outstanding = 0;
      fail_count  = 0;
      checked     = 0;
   end

   function automatic int unsigned bubble_up(int unsigned pos, logic [KEY_W-1:0] k,
                                             logic [CNT_W-1:0] v);
      while (pos + 1 < live && v > count_at[pos + 1]) begin
         key_at[pos]           = key_at[pos + 1];
         count_at[pos]         = count_at[pos + 1];
         rank_of[key_at[pos]]  = RANK_W'(pos);
         pos++;
      end
      key_at[pos]   = k;
      count_at[pos] = v;
      rank_of[k]    = RANK_W'(pos);
      return pos;
   endfunction

   function automatic int unsigned bubble_down(int unsigned pos, logic [KEY_W-1:0] k,
                                               logic [CNT_W-1:0] v);
      while (pos > 0 && v < count_at[pos - 1]) begin
         key_at[pos]           = key_at[pos - 1];
         count_at[pos]         = count_at[pos - 1];
         rank_of[key_at[pos]]  = RANK_W'(pos);
         pos--;
      end
      key_at[pos]   = k;
      count_at[pos] = v;
      rank_of[k]    = RANK_W'(pos);
      return pos;
   endfunction

   function automatic rsp_type apply_command(req_type r);
      rsp_type          res;
      int unsigned      pos;
      int unsigned      last;
      logic [CNT_W-1:0] v;
      logic [CNT_W-1:0] sum;
      logic [KEY_W-1:0] moved_key;
      logic [CNT_W-1:0] moved_count;
      logic             active;
      res = '0;
      case (r.command)
         CMD_QRANK: begin
            res.key_out   = key_at[r.rank];
            res.count_out = count_at[r.rank];
            res.ok        = (r.rank < live);
            res.rank_out  = r.rank;
         end
         CMD_INC, CMD_DEC, CMD_REMOVE, CMD_QKEY: begin
            res.key_out = r.key;
            pos         = rank_of[r.key];
            v           = count_at[pos];
            active      = (pos < live);
            if (r.command == CMD_QKEY || !active) begin
               res.ok = (r.command == CMD_QKEY) && active;
            end else if (r.command == CMD_INC) begin
               sum = v + r.amount;
               if (sum < v) sum = '1;
               pos    = bubble_up(pos, r.key, sum);
               res.ok = 1'b1;
            end else if (r.command == CMD_DEC) begin
               if (v >= r.amount) begin
                  pos    = bubble_down(pos, r.key, v - r.amount);
                  res.ok = 1'b1;
               end
            end else begin
               last           = live - 1;
               moved_key      = key_at[last];
               moved_count    = count_at[last];
               live           = last;
               key_at[last]   = r.key;
               count_at[last] = v;
               rank_of[r.key] = RANK_W'(last);
               if (pos != last) void'(bubble_up(pos, moved_key, moved_count));
               pos    = last;
               res.ok = 1'b1;
            end
            res.count_out = count_at[pos];
            res.rank_out  = RANK_W'(pos);
         end
         default: ;
      endcase
      res.active_out = ACT_W'(live);
      return res;
   endfunction

   function automatic void compare_field(string name, logic [CNT_W-1:0] want,
                                         logic [CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEF_ENTRIES; i++) begin
            key_at[i]   = KEY_W'(i);
            count_at[i] = '0;
            rank_of[i]  = RANK_W'(i);
         end
         live = DEF_ENTRIES;
         pending_results.delete();
      end else begin
         if (req_valid && !req_stall) pending_results.push_back(apply_command(req_data));
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0h", $time, rsp_data);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("ok", want.ok, rsp_data.ok);
               compare_field("key_out", want.key_out, rsp_data.key_out);
               compare_field("count_out", want.count_out, rsp_data.count_out);
               compare_field("rank_out", want.rank_out, rsp_data.rank_out);
               compare_field("active_out", want.active_out, rsp_data.active_out);
            end
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import sbft_pkg::*;

   localparam logic [CMD_W-1:0] CMD_LAST = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int outstanding;
   int fail_count;
   int checked;
   int sent;
   int rsp_wait;
   bit quiet;

   sorted_byte_frequency_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rank_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .fail_count  (fail_count),
      .checked     (checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  = 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait   = quiet ? 0 : $urandom_range(0, 18);
         rsp_stall <= (rsp_wait != 0);
      end else if (rsp_valid && rsp_stall) begin
         rsp_wait--;
         rsp_stall <= (rsp_wait != 0);
      end
   end

   function automatic req_type make_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                        logic [CNT_W-1:0] a, logic [RANK_W-1:0] r);
      req_type t;
      t.command = c;
      t.key     = k;
      t.amount  = a;
      t.rank    = r;
      return t;
   endfunction

   task automatic send_item(req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic req_type random_cmd();
      req_type t;
      int      pick;
      t.key  = ($urandom_range(0, 9) < 6) ? KEY_W'($urandom_range(0, 15))
                                          : KEY_W'($urandom);
      t.rank = RANK_W'($urandom);
      pick   = $urandom_range(0, 9);
      if (pick < 7)       t.amount = $urandom_range(0, 20);
      else if (pick == 7) t.amount = $urandom;
      else if (pick == 8) t.amount = '1 - $urandom_range(0, 20);
      else                t.amount = CNT_W'(1) << $urandom_range(0, CNT_W - 1);
      pick = $urandom_range(0, 99);
      if (pick < 45)      t.command = CMD_INC;
      else if (pick < 65) t.command = CMD_DEC;
      else if (pick < 70) t.command = CMD_REMOVE;
      else if (pick < 80) t.command = CMD_QRANK;
      else if (pick < 95) t.command = CMD_QKEY;
      else t.command = CMD_W'($urandom_range(int'(CMD_QKEY) + 1, int'(CMD_LAST)));
      return t;
   endfunction

   initial begin
      req_type directed [$];
      sent  = 0;
      quiet = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_cmd(CMD_QRANK, 8'd0, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_QRANK, 8'd0, 32'd0, 8'hFF));
      directed.push_back(make_cmd(CMD_QKEY, 8'd0, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_QKEY, 8'hFF, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'hFF, 32'hFFFF_FFFF, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'hFF, 32'd1, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'd0, 32'hFFFF_FFFF, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'd0, 32'd5, 8'd0));
      directed.push_back(make_cmd(CMD_DEC, 8'd7, 32'd1, 8'd0));
      directed.push_back(make_cmd(CMD_DEC, 8'd7, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_DEC, 8'd0, 32'hFFFF_FFFF, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'd128, 32'h5555_5555, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'd129, 32'hAAAA_AAAA, 8'd0));
      directed.push_back(make_cmd(CMD_REMOVE, 8'd3, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_REMOVE, 8'd3, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_INC, 8'd3, 32'd9, 8'd0));
      directed.push_back(make_cmd(CMD_DEC, 8'd3, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_QKEY, 8'd3, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_QRANK, 8'd0, 32'd0, 8'hFF));
      directed.push_back(make_cmd(CMD_QRANK, 8'd0, 32'd0, 8'hFE));
      directed.push_back(make_cmd(CMD_REMOVE, 8'hFF, 32'd0, 8'd0));
      directed.push_back(make_cmd(CMD_QKEY + 3'd1, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
      directed.push_back(make_cmd(CMD_QKEY + 3'd2, 8'h5A, 32'h1234_5678, 8'hA5));
      directed.push_back(make_cmd(CMD_LAST, 8'h00, 32'h0, 8'h00));
      foreach (directed[i]) send_item(directed[i]);

      for (int i = 0; i < 720; i++) begin
         if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (i == 500) wait_drained();
         send_item(random_cmd());
      end

      quiet = 1'b0;
      for (int k = 0; k < DEF_ENTRIES; k++) begin
         send_item(make_cmd(CMD_REMOVE, KEY_W'(k), $urandom, RANK_W'($urandom)));
      end
      for (int i = 0; i < 12; i++) send_item(random_cmd());

      wait_drained();
      repeat (DEF_ENTRIES + 10) @(posedge clock);

      $display("Sent %0d commands, checked %0d results against the predicted table",
               sent, checked);
      $display("Ran saturation, underflow refusal, unknown codes and removal of every key");
      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
